>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the house clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/mrft_pkg.sv
// ----------------------------------------------------------------------------
// mrft_pkg
// Types, codes and the CRC-16/MODBUS byte update for the RTU transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mrft_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0]  MaxFrameReset    = 8'd100;
  localparam logic [7:0]  AnswerCapReset   = 8'd255;
  localparam logic [15:0] IdleTimeoutReset = 16'd20;

  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_RECV  = 2'd1,
    OP_TICK  = 2'd2
  } mrft_op_e;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_TOOLONG = 2'd3
  } mrft_kind_e;

  typedef enum logic [1:0] {
    REG_MAX_FRAME    = 2'd0,
    REG_ANSWER_CAP   = 2'd1,
    REG_IDLE_TIMEOUT = 2'd2
  } mrft_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_REPLY = 3'b010,
    PH_DROP  = 3'b100
  } mrft_phase_e;

  typedef struct packed {
    logic [7:0]  max_frame;
    logic [7:0]  answer_cap;
    logic [15:0] idle_timeout;
  } mrft_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] position;
    logic       run_end;
  } mrft_result_t;

  typedef struct packed {
    logic                               valid;
    logic [1:0]                         cnt;
    mrft_result_t [MaxResults-1:0]      res;
  } mrft_push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrft_in_if.sv
// ----------------------------------------------------------------------------
// mrft_in_if
// Input channel: frame bytes, received line bytes and timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrft_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output opcode, output data_byte, output final_byte,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input final_byte,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/mrft_out_if.sv
// ----------------------------------------------------------------------------
// mrft_out_if
// Result channel: line bytes, stored reply bytes and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [7:0] position;
  logic       run_end;

  modport source (output valid, output kind, output byte_value, output position,
                  output run_end, input ready);
  modport sink (input valid, input kind, input byte_value, input position,
                input run_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mrft_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrft_cfg_regs
// APB-style configuration registers: frame limit, answer capacity, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module mrft_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mrft_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output mrft_pkg::mrft_cfg_t                   cfg_o
);
  import mrft_pkg::*;

  mrft_cfg_t cfg_q;
  logic      wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame    <= MaxFrameReset;
      cfg_q.answer_cap   <= AnswerCapReset;
      cfg_q.idle_timeout <= IdleTimeoutReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_FRAME:    cfg_q.max_frame    <= pwdata[7:0];
        REG_ANSWER_CAP:   cfg_q.answer_cap   <= pwdata[7:0];
        REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_FRAME:    prdata = {24'h0, cfg_q.max_frame};
      REG_ANSWER_CAP:   prdata = {24'h0, cfg_q.answer_cap};
      REG_IDLE_TIMEOUT: prdata = {16'h0, cfg_q.idle_timeout};
      default:          prdata = 32'h0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/mrft_engine.sv
// ----------------------------------------------------------------------------
// mrft_engine
// Input register, framing state and CRC; builds the results of one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrft_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  mrft_pkg::mrft_cfg_t       cfg_i,
  mrft_in_if.sink                   in_i,
  output mrft_pkg::mrft_push_t      push_o,
  input  wire logic                 push_ready_i
);
  import mrft_pkg::*;

  logic        vld_q;
  logic [1:0]  op_q;
  logic [7:0]  data_q;
  logic        fin_q;

  mrft_phase_e phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  fc_q, fc_d;
  logic [7:0]  rl_q, rl_d;
  logic [15:0] ic_q, ic_d;

  logic [15:0] crc_new;
  logic [15:0] ic_inc;
  logic [1:0]  n;
  mrft_result_t [MaxResults-1:0] res;
  logic        fire;

  assign crc_new = crc16_byte(crc_q, data_q);
  assign ic_inc  = (ic_q == 16'hFFFF) ? ic_q : ic_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    fc_d    = fc_q;
    rl_d    = rl_q;
    ic_d    = ic_q;
    n       = 2'd0;
    res     = '0;
    unique case (op_q)
      OP_FRAME: begin
        if (phase_q == PH_IDLE) begin
          if (fc_q >= cfg_i.max_frame) begin
            res[0].kind    = KIND_TOOLONG;
            res[0].run_end = 1'b1;
            n = 2'd1;
            if (fin_q) begin
              crc_d = CrcInit;
              fc_d  = 8'd0;
            end else begin
              phase_d = PH_DROP;
            end
          end else begin
            fc_d  = fc_q + 8'd1;
            crc_d = crc_new;
            res[0].kind       = KIND_SEND;
            res[0].byte_value = data_q;
            if (fin_q) begin
              res[1].kind       = KIND_SEND;
              res[1].byte_value = crc_new[7:0];
              res[2].kind       = KIND_SEND;
              res[2].byte_value = crc_new[15:8];
              res[2].run_end    = 1'b1;
              n       = 2'd3;
              phase_d = PH_REPLY;
              rl_d    = 8'd0;
              ic_d    = 16'd0;
            end else begin
              res[0].run_end = 1'b1;
              n = 2'd1;
            end
          end
        end else if (phase_q == PH_DROP && fin_q) begin
          // drop ends with the final byte: back to idle with a fresh CRC
          phase_d = PH_IDLE;
          crc_d   = CrcInit;
          fc_d    = 8'd0;
        end
      end
      OP_RECV: begin
        if (phase_q == PH_REPLY) begin
          ic_d = 16'd0;
          if (rl_q < cfg_i.answer_cap) begin
            res[0].kind       = KIND_STORE;
            res[0].byte_value = data_q;
            res[0].position   = rl_q;
            res[0].run_end    = 1'b1;
            n    = 2'd1;
            rl_d = rl_q + 8'd1;
          end
        end
      end
      OP_TICK: begin
        if (phase_q == PH_REPLY) begin
          ic_d = ic_inc;
          if (ic_inc >= cfg_i.idle_timeout) begin
            res[0].kind     = KIND_DONE;
            res[0].position = rl_q;
            res[0].run_end  = 1'b1;
            n       = 2'd1;
            phase_d = PH_IDLE;
            crc_d   = CrcInit;
            fc_d    = 8'd0;
            rl_d    = 8'd0;
            ic_d    = 16'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // items without results never wait for the result buffer
  assign fire       = vld_q && ((n == 2'd0) || push_ready_i);
  assign in_i.ready = !vld_q || fire;

  assign push_o.valid = vld_q && (n != 2'd0);
  assign push_o.cnt   = n;
  assign push_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q   <= in_i.opcode;
      data_q <= in_i.data_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= CrcInit;
      fc_q    <= 8'd0;
      rl_q    <= 8'd0;
      ic_q    <= 16'd0;
    end else if (fire) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      fc_q    <= fc_d;
      rl_q    <= rl_d;
      ic_q    <= ic_d;
    end
  end

  `ASSERT_STD(a_idle_clean, (phase_q == PH_IDLE) |-> (rl_q == 8'd0 && ic_q == 16'd0),
              "reply state left over while idle")
  `ASSERT_STD(a_three_only_final, (vld_q && n == 2'd3) |-> (op_q == OP_FRAME && fin_q),
              "three results from an item that is not a final frame byte")

endmodule

`default_nettype wire

>>> rtl/core/mrft_out_buf.sv
// ----------------------------------------------------------------------------
// mrft_out_buf
// Result buffer: holds up to three results of one item and drains them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrft_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  mrft_pkg::mrft_push_t  push_i,
  output logic                  push_ready_o,
  mrft_out_if.source            out_o
);
  import mrft_pkg::*;

  mrft_result_t [MaxResults-1:0] res_q;
  logic [1:0]   cnt_q;
  logic [1:0]   idx_q;
  mrft_result_t head;
  logic         pop;

  always_comb begin
    unique case (idx_q)
      2'd1:    head = res_q[1];
      2'd2:    head = res_q[2];
      default: head = res_q[0];
    endcase
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.kind       = head.kind;
  assign out_o.byte_value = head.byte_value;
  assign out_o.position   = head.position;
  assign out_o.run_end    = head.run_end;

  assign pop          = out_o.valid && out_o.ready;
  // refill in the cycle the last result leaves
  assign push_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (push_i.valid && push_ready_o) begin
      cnt_q <= push_i.cnt;
      idx_q <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && push_ready_o) begin
      res_q <= push_i.res;
    end
  end

  `ASSERT_STD(a_idx_in_range, ({1'b0, idx_q} + {1'b0, cnt_q}) <= 3'd3,
              "result index runs past the buffer")
  `ASSERT_STD(a_run_end_last, out_o.valid |-> (out_o.run_end == (cnt_q == 2'd1)),
              "run end not on the last result of an item")

endmodule

`default_nettype wire

>>> rtl/core/modbus_rtu_frame_transceiver.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_transceiver
// Modbus RTU request framer with CRC-16/MODBUS and reply collector.
// in_i carries frame bytes to send, bytes received from the line and timer
// ticks; out_o delivers line bytes, stored reply bytes, the reply length on
// timeout and a frame-too-long flag, run_end marking an item's last result.
// The APB port sets frame limit, answer capacity and idle timeout.
// An accepted item is held in the input register and evaluated there in a
// single pass; its results are registered in the result buffer and drain.
// The engine takes one item per cycle while the result buffer takes its
// results; an item with k results holds the result buffer for k output
// transactions, so a final frame byte (data plus two CRC bytes) holds it
// for three and every other item for at most one; items without results
// pass whatever the output does. When the receiver stalls, results hold and
// the input register fills, then in_i.ready drops. Reset empties both
// registers, returns to idle with the CRC at 0xFFFF and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_frame_transceiver (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mrft_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  mrft_in_if.sink                               in_i,
  mrft_out_if.source                            out_o
);
  import mrft_pkg::*;

  mrft_cfg_t  cfg;
  mrft_push_t push;
  logic       push_ready;

  mrft_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrft_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  mrft_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
